// File: sv/gzhp_pkg.sv
// gzhp_pkg: shared types and constants for the gzip header parser
// transfer payload structs, status and error codes, header byte values
// no dependencies
`default_nettype none

package gzhp_pkg;

    localparam int LEN_BITS = 20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [1:0]          error_kind;
        logic [7:0]          name_byte;
        logic [LEN_BITS-1:0] header_len;
    } out_item_t;

    // status codes
    localparam logic [2:0] ST_HEADER  = 3'd0;
    localparam logic [2:0] ST_NAME    = 3'd1;
    localparam logic [2:0] ST_DONE    = 3'd2;
    localparam logic [2:0] ST_PAYLOAD = 3'd3;
    localparam logic [2:0] ST_ERROR   = 3'd4;

    // error kinds
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_MAGIC  = 2'd1;
    localparam logic [1:0] ERR_METHOD = 2'd2;
    localparam logic [1:0] ERR_TRUNC  = 2'd3;

    // fixed header byte values
    localparam logic [7:0] MAGIC1_BYTE   = 8'h1F;
    localparam logic [7:0] MAGIC2_BYTE   = 8'h8B;
    localparam logic [7:0] DEFLATE_BYTE  = 8'h08;
    localparam logic [7:0] NUL_BYTE      = 8'h00;
    localparam logic [15:0] FIXED_SKIP   = 16'd6;
    localparam logic [15:0] HCRC_SKIP    = 16'd2;

    // bit positions in the latched flag field (flag byte shifted right by one)
    localparam int FL_HCRC    = 0;
    localparam int FL_EXTRA   = 1;
    localparam int FL_NAME    = 2;
    localparam int FL_COMMENT = 3;

endpackage

`default_nettype wire

// File: sv/gzhp_parse.sv
// gzhp_parse: header phase tracking and per-byte result decode
// holds the parse state and header byte counter, one byte per cycle while step is high
// depends on gzhp_pkg
`default_nettype none

module gzhp_parse #(
    parameter int COUNT_BITS = 20
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     step,
    input  wire gzhp_pkg::in_item_t item,
    input  wire                     name_report,
    output gzhp_pkg::out_item_t     result
);

    typedef enum logic [3:0] {
        PH_MAGIC1,
        PH_MAGIC2,
        PH_METHOD,
        PH_FLAGS,
        PH_FIXED,
        PH_XLO,
        PH_XHI,
        PH_EXTRA,
        PH_NAME,
        PH_COMMENT,
        PH_HCRC,
        PH_BODY,
        PH_PAYLOAD,
        PH_ERR_MAGIC,
        PH_ERR_METHOD
    } phase_t;

    localparam int LB = gzhp_pkg::LEN_BITS;

    phase_t                phase_reg, phase_next;
    logic [3:0]            flags_reg, flags_next;
    logic [15:0]           skip_reg, skip_next;
    logic [7:0]            xlen_lo_reg, xlen_lo_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic [15:0]           skip_dec;
    logic [15:0]           xlen_full;
    logic [COUNT_BITS+LB-1:0] count_ext;
    logic [LB-1:0]         len_sat;

    // skip sections whose flag is clear
    function automatic phase_t enter_phase(input phase_t p, input logic [3:0] fl);
        phase_t q;
        q = p;
        if (q == PH_XLO && !fl[gzhp_pkg::FL_EXTRA]) q = PH_NAME;
        if (q == PH_NAME && !fl[gzhp_pkg::FL_NAME]) q = PH_COMMENT;
        if (q == PH_COMMENT && !fl[gzhp_pkg::FL_COMMENT]) q = PH_HCRC;
        if (q == PH_HCRC && !fl[gzhp_pkg::FL_HCRC]) q = PH_BODY;
        return q;
    endfunction

    assign skip_dec  = skip_reg - 16'd1;
    assign xlen_full = {item.data_byte, xlen_lo_reg};
    assign count_ext = {{LB{1'b0}}, count_reg};
    assign len_sat   = (|count_ext[COUNT_BITS+LB-1:LB]) ? {LB{1'b1}} : count_ext[LB-1:0];

    always_comb
    begin
        phase_next   = phase_reg;
        flags_next   = flags_reg;
        skip_next    = skip_reg;
        xlen_lo_next = xlen_lo_reg;
        count_next   = count_reg;
        result       = '0;

        if (phase_reg <= PH_HCRC && count_reg != {COUNT_BITS{1'b1}})
            count_next = count_reg + 1'b1;

        case (phase_reg)
            PH_MAGIC1:
            begin
                if (item.data_byte != gzhp_pkg::MAGIC1_BYTE)
                begin
                    result.status     = gzhp_pkg::ST_ERROR;
                    result.error_kind = gzhp_pkg::ERR_MAGIC;
                    phase_next        = PH_ERR_MAGIC;
                end
                else
                    phase_next = PH_MAGIC2;
            end
            PH_MAGIC2:
            begin
                if (item.data_byte != gzhp_pkg::MAGIC2_BYTE)
                begin
                    result.status     = gzhp_pkg::ST_ERROR;
                    result.error_kind = gzhp_pkg::ERR_MAGIC;
                    phase_next        = PH_ERR_MAGIC;
                end
                else
                    phase_next = PH_METHOD;
            end
            PH_METHOD:
            begin
                if (item.data_byte != gzhp_pkg::DEFLATE_BYTE)
                begin
                    result.status     = gzhp_pkg::ST_ERROR;
                    result.error_kind = gzhp_pkg::ERR_METHOD;
                    phase_next        = PH_ERR_METHOD;
                end
                else
                    phase_next = PH_FLAGS;
            end
            PH_FLAGS:
            begin
                flags_next = item.data_byte[4:1];
                skip_next  = gzhp_pkg::FIXED_SKIP;
                phase_next = PH_FIXED;
            end
            PH_FIXED:
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                    phase_next = enter_phase(PH_XLO, flags_reg);
            end
            PH_XLO:
            begin
                xlen_lo_next = item.data_byte;
                phase_next   = PH_XHI;
            end
            PH_XHI:
            begin
                skip_next = xlen_full;
                if (xlen_full == 16'd0)
                    phase_next = enter_phase(PH_NAME, flags_reg);
                else
                    phase_next = PH_EXTRA;
            end
            PH_EXTRA:
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                    phase_next = enter_phase(PH_NAME, flags_reg);
            end
            PH_NAME:
            begin
                if (item.data_byte == gzhp_pkg::NUL_BYTE)
                    phase_next = enter_phase(PH_COMMENT, flags_reg);
                else if (name_report)
                begin
                    result.status    = gzhp_pkg::ST_NAME;
                    result.name_byte = item.data_byte;
                end
            end
            PH_COMMENT:
            begin
                if (item.data_byte == gzhp_pkg::NUL_BYTE)
                    phase_next = enter_phase(PH_HCRC, flags_reg);
            end
            PH_HCRC:
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                    phase_next = PH_BODY;
            end
            PH_BODY:
            begin
                result.status     = gzhp_pkg::ST_DONE;
                result.header_len = len_sat;
                phase_next        = PH_PAYLOAD;
            end
            PH_PAYLOAD:
                result.status = gzhp_pkg::ST_PAYLOAD;
            PH_ERR_MAGIC:
            begin
                result.status     = gzhp_pkg::ST_ERROR;
                result.error_kind = gzhp_pkg::ERR_MAGIC;
            end
            default:
            begin
                result.status     = gzhp_pkg::ST_ERROR;
                result.error_kind = gzhp_pkg::ERR_METHOD;
            end
        endcase

        // crc skip count is loaded whenever the crc section is entered
        if (phase_next == PH_HCRC && phase_reg != PH_HCRC)
            skip_next = gzhp_pkg::HCRC_SKIP;

        if (item.last_byte)
        begin
            if (result.status == gzhp_pkg::ST_HEADER || result.status == gzhp_pkg::ST_NAME)
            begin
                result.status     = gzhp_pkg::ST_ERROR;
                result.error_kind = gzhp_pkg::ERR_TRUNC;
                result.name_byte  = '0;
            end
            phase_next   = PH_MAGIC1;
            flags_next   = '0;
            skip_next    = '0;
            xlen_lo_next = '0;
            count_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_MAGIC1;
            flags_reg   <= '0;
            skip_reg    <= '0;
            xlen_lo_reg <= '0;
            count_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            flags_reg   <= flags_next;
            skip_reg    <= skip_next;
            xlen_lo_reg <= xlen_lo_next;
            count_reg   <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/gzip_header_parser.sv
// gzip_header_parser: one result per byte, result registered, one transfer per cycle while in_ready is high
// a byte's result is registered into the output register, or into the skid register while the output stalls
// throughput: one byte per cycle while the skid register is empty, set by the phase update in gzhp_parse
// a two-entry output (result register plus skid register) keeps input ready registered
// reset: asynchronous active-low; parse state cleared, name_report set to 1, outputs empty
// depends on gzhp_pkg and gzhp_parse
`default_nettype none

module gzip_header_parser #(
    parameter int COUNT_BITS = 20
) (
    input  wire                     clk,
    input  wire                     rst_n,
    // byte stream in
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire gzhp_pkg::in_item_t in_data,
    // results out
    output logic                    out_valid,
    input  wire                     out_ready,
    output gzhp_pkg::out_item_t     out_data,
    // name_report register write
    input  wire                     cfg_we,
    input  wire                     cfg_wdata
);

    logic                name_report_reg;
    logic                out_valid_reg;
    logic                skid_valid_reg;
    gzhp_pkg::out_item_t out_reg;
    gzhp_pkg::out_item_t skid_reg;
    gzhp_pkg::out_item_t step_result;

    logic in_xfer;
    logic out_xfer;

    // input is taken whenever the skid slot is free
    assign in_ready  = !skid_valid_reg;
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // parse state advances on every input transfer
    gzhp_parse #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (in_xfer),
        .item        (in_data),
        .name_report (name_report_reg),
        .result      (step_result)
    );

    // config register: the user must write it only while idle; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            name_report_reg <= 1'b1;
        else if (cfg_we)
            name_report_reg <= cfg_wdata;
    end

    // output control: skid empties into the result register first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_xfer)
                skid_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            if (out_valid_reg && !out_ready)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_xfer)
            out_valid_reg <= 1'b0;
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_xfer)
                out_reg <= skid_reg;
        end
        else if (in_xfer)
        begin
            if (out_valid_reg && !out_ready)
                skid_reg <= step_result;
            else
                out_reg <= step_result;
        end
    end

endmodule

`default_nettype wire
